@@ rtl/lu_pkg.sv @@
// ----------------------------------------------------------------------------
// LU solver package
// Shared widths, command and status codes, divider result type.
// ----------------------------------------------------------------------------
package lu_pkg;

   localparam int VAL_W  = 32;   // Q16.16 word
   localparam int IDX_W  = 4;    // row / column / solution index
   localparam int DIM_W  = 5;    // holds a dimension up to 16
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;
   localparam int CSR_W  = 1;    // register index width
   localparam int HARD_CAP = 16; // largest dimension the index fields reach

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_M = 2'd0,
      CMD_LOAD_V = 2'd1,
      CMD_SOLVE  = 2'd2
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_PIVOT = 2'd1,
      ST_OVF   = 2'd2
   } status_type;

   typedef enum logic [CSR_W-1:0] {
      REG_MATRIX_SIZE = 1'b0,
      REG_PIVOT_MIN   = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic              ovf;
      logic [VAL_W-1:0]  value;
   } div_res_type;

endpackage

@@ rtl/lu_channels_if.sv @@
// ----------------------------------------------------------------------------
// LU solver channels
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface lu_req_if;
   logic                        valid;
   logic                        ready;
   logic [lu_pkg::CMD_W-1:0]    command;
   logic [lu_pkg::IDX_W-1:0]    row;
   logic [lu_pkg::IDX_W-1:0]    col;
   logic signed [lu_pkg::VAL_W-1:0] value;
   modport source (output valid, command, row, col, value, input ready);
   modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface lu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lu_pkg::IDX_W-1:0]    index;
   logic signed [lu_pkg::VAL_W-1:0] solution;
   logic                        last;
   logic [lu_pkg::STAT_W-1:0]   status;
   modport source (output valid, index, solution, last, status, input ready);
   modport sink   (input valid, index, solution, last, status, output ready);
endinterface

interface lu_csr_if;
   logic                        valid;
   logic                        ready;
   logic [lu_pkg::CSR_W-1:0]    index;
   logic [lu_pkg::VAL_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/lu_ram.sv @@
// ----------------------------------------------------------------------------
// LU solver RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/lu_div.sv @@
// ----------------------------------------------------------------------------
// LU solver divider
// Q16.16 quotient (a<<16)/b, truncated toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module lu_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [lu_pkg::VAL_W-1:0]  dividend,
   input  logic signed [lu_pkg::VAL_W-1:0]  divisor,
   output logic                             done,
   output lu_pkg::div_res_type              res
);
   localparam int W     = lu_pkg::VAL_W;
   localparam int Q_W   = W + 16;
   localparam int CNT_W = $clog2(Q_W);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [Q_W-1:0]   quo_ff, quo_in;
   logic [W-1:0]     den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [W:0]       shifted;
   logic [W-1:0]     mag_a;
   logic [W-1:0]     mag_b;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      mag_a     = dividend[W-1] ? W'(-dividend) : W'(dividend);
      mag_b     = divisor[W-1]  ? W'(-divisor)  : W'(divisor);
      shifted   = {rem_ff, quo_ff[Q_W-1]};
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_W'(Q_W - 1);
         rem_in    = '0;
         quo_in    = {mag_a, 16'h0000};
         den_in    = mag_b;
         neg_in    = dividend[W-1] ^ divisor[W-1];
      end else if (active_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = W'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // saturate the signed quotient to 32 bits
   always_comb begin
      res.ovf   = 1'b0;
      res.value = neg_ff ? W'(-quo_ff[W-1:0]) : quo_ff[W-1:0];
      if (!neg_ff && (quo_ff[Q_W-1:W-1] != '0)) begin
         res.ovf   = 1'b1;
         res.value = {1'b0, {(W-1){1'b1}}};
      end else if (neg_ff && (quo_ff > Q_W'({1'b1, {(W-1){1'b0}}}))) begin
         res.ovf   = 1'b1;
         res.value = {1'b1, {(W-1){1'b0}}};
      end
   end

   assign done = done_ff;
endmodule

@@ rtl/lu_decomposition_solver.sv @@
// ----------------------------------------------------------------------------
// LU decomposition solver
// Doolittle factorization in place, forward and back substitution, Q16.16.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | notes
//  req     | in  | command, row, col, value         | loads taken while idle
//  rsp     | out | index, solution, last, status    | n results or 1 error
//  csr     | in  | index, data                      | always ready
//
//  Loads are taken one per cycle. A solve holds req.ready low until its last
//  response is taken. Each multiply-subtract is three reads from the
//  matrix/vector RAMs, a multiply and an update; each divide runs the
//  bit-serial divider. Stalls on rsp hold the sequencer. Reset clears
//  control only; store entries read before being written return arbitrary
//  data.
// ----------------------------------------------------------------------------
module lu_decomposition_solver #(
   parameter int MAX_DIM = 16
) (
   input  logic     clock,
   input  logic     reset,
   lu_req_if.sink   req,
   lu_rsp_if.source rsp,
   lu_csr_if.sink   csr
);
   localparam int W       = lu_pkg::VAL_W;
   localparam int DW      = lu_pkg::DIM_W;
   localparam int IW      = lu_pkg::IDX_W;
   localparam int M_DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW      = $clog2(M_DEPTH);
   localparam int VW      = $clog2(MAX_DIM);
   localparam int DIM_CAP = (MAX_DIM < lu_pkg::HARD_CAP) ? MAX_DIM : lu_pkg::HARD_CAP;

   typedef enum logic [14:0] {
      S_IDLE     = 15'b000000000000001,
      S_DISP     = 15'b000000000000010,
      S_RD_T     = 15'b000000000000100,
      S_RD_A     = 15'b000000000001000,
      S_RD_B     = 15'b000000000010000,
      S_CAP_B    = 15'b000000000100000,
      S_MUL      = 15'b000000001000000,
      S_UPD      = 15'b000000010000000,
      S_DIV      = 15'b000000100000000,
      S_PIV_RD   = 15'b000001000000000,
      S_PIV_CHK  = 15'b000010000000000,
      S_OUT_RD   = 15'b000100000000000,
      S_OUT_CAP  = 15'b001000000000000,
      S_OUT_HOLD = 15'b010000000000000,
      S_WAIT     = 15'b100000000000000
   } state_type;

   typedef enum logic [4:0] {
      PH_U = 5'b00001,
      PH_L = 5'b00010,
      PH_F = 5'b00100,
      PH_B = 5'b01000,
      PH_O = 5'b10000
   } phase_type;

   typedef struct packed {
      logic          vec;
      logic [IW-1:0] row;
      logic [IW-1:0] col;
   } opnd_type;

   function automatic opnd_type mk(input logic v, input logic [DW-1:0] rw,
                                   input logic [DW-1:0] cl);
      opnd_type o;
      o.vec = v;
      o.row = rw[IW-1:0];
      o.col = cl[IW-1:0];
      return o;
   endfunction

   function automatic logic [AW-1:0] m_addr(input logic [IW-1:0] rw,
                                            input logic [IW-1:0] cl);
      return AW'(AW'(rw) * AW'(MAX_DIM) + AW'(cl));
   endfunction

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [DW-1:0]        n_ff, n_in;
   logic [DW-1:0]        p_ff, p_in, i_ff, i_in, j_ff, j_in, r_ff, r_in;
   logic                 div_ff, div_in;
   logic                 ovf_ff, ovf_in;
   logic [DW-1:0]        size_ff, size_in;
   logic [W-2:0]         pmin_ff, pmin_in;
   logic signed [W-1:0]  t_ff, t_in, a_ff, a_in, b_ff, b_in;
   logic signed [63:0]   prod_ff, prod_in;
   logic                 rd_vec_ff;
   logic                 rv_ff, rv_in;
   logic [IW-1:0]        ridx_ff, ridx_in;
   logic [W-1:0]         rsol_ff, rsol_in;
   logic                 rlast_ff, rlast_in;
   logic [lu_pkg::STAT_W-1:0] rstat_ff, rstat_in;

   opnd_type             t_desc, a_desc, b_desc, rd_desc;
   logic [DW-1:0]        im1;
   logic [W-1:0]         m_rdata, v_rdata, rd_data;
   logic                 m_we, v_we;
   logic [AW-1:0]        m_waddr;
   logic [VW-1:0]        v_waddr;
   logic [W-1:0]         wdata;
   logic                 div_start, div_done;
   lu_pkg::div_res_type  div_res;
   logic signed [63:0]   rnd;
   logic signed [47:0]   qm;
   logic signed [48:0]   diff;
   logic [W-1:0]         upd_val;
   logic                 upd_ovf;
   logic [W-1:0]         piv_mag;
   logic                 accept;

   assign accept = req.valid && req.ready;
   assign im1    = i_ff - DW'(1);

   // operand selection per loop phase
   always_comb begin
      t_desc = mk(1'b0, p_ff, p_ff);
      a_desc = mk(1'b0, p_ff, p_ff);
      b_desc = mk(1'b0, p_ff, p_ff);
      case (phase_ff)
         PH_U: begin
            t_desc = mk(1'b0, p_ff, j_ff);
            a_desc = mk(1'b0, p_ff, r_ff);
            b_desc = mk(1'b0, r_ff, j_ff);
         end
         PH_L: begin
            t_desc = mk(1'b0, i_ff, p_ff);
            a_desc = div_ff ? mk(1'b0, p_ff, p_ff) : mk(1'b0, i_ff, r_ff);
            b_desc = mk(1'b0, r_ff, p_ff);
         end
         PH_F: begin
            t_desc = mk(1'b1, i_ff, '0);
            a_desc = mk(1'b0, i_ff, j_ff);
            b_desc = mk(1'b1, j_ff, '0);
         end
         PH_B: begin
            t_desc = mk(1'b1, im1, '0);
            a_desc = div_ff ? mk(1'b0, im1, im1) : mk(1'b0, im1, j_ff);
            b_desc = mk(1'b1, j_ff, '0);
         end
         default: begin
            t_desc = mk(1'b1, i_ff, '0);
         end
      endcase
      case (state_ff)
         S_RD_T:   rd_desc = t_desc;
         S_RD_A:   rd_desc = a_desc;
         S_RD_B:   rd_desc = b_desc;
         S_OUT_RD: rd_desc = mk(1'b1, i_ff, '0);
         default:  rd_desc = mk(1'b0, p_ff, p_ff);
      endcase
   end

   assign rd_data = rd_vec_ff ? v_rdata : m_rdata;

   // rounded product, subtract, saturate
   always_comb begin
      rnd     = prod_ff + 64'sd32768;
      qm      = rnd[63:16];
      diff    = {{17{t_ff[W-1]}}, t_ff} - {qm[47], qm};
      upd_ovf = 1'b0;
      upd_val = diff[W-1:0];
      if (!diff[48] && (diff[47:W-1] != '0)) begin
         upd_ovf = 1'b1;
         upd_val = {1'b0, {(W-1){1'b1}}};
      end else if (diff[48] && (diff[47:W-1] != '1)) begin
         upd_ovf = 1'b1;
         upd_val = {1'b1, {(W-1){1'b0}}};
      end
      piv_mag = rd_data[W-1] ? W'(-rd_data) : rd_data;
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      n_in      = n_ff;
      p_in      = p_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      r_in      = r_ff;
      div_in    = div_ff;
      ovf_in    = ovf_ff;
      size_in   = size_ff;
      pmin_in   = pmin_ff;
      t_in      = t_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      prod_in   = prod_ff;
      rv_in     = rv_ff;
      ridx_in   = ridx_ff;
      rsol_in   = rsol_ff;
      rlast_in  = rlast_ff;
      rstat_in  = rstat_ff;
      m_we      = 1'b0;
      v_we      = 1'b0;
      m_waddr   = m_addr(t_desc.row, t_desc.col);
      v_waddr   = VW'(t_desc.row);
      wdata     = upd_val;
      div_start = 1'b0;

      if (csr.valid) begin
         case (csr.index)
            lu_pkg::REG_MATRIX_SIZE: size_in = csr.data[DW-1:0];
            lu_pkg::REG_PIVOT_MIN:   pmin_in = csr.data[W-2:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            m_waddr = m_addr(req.row, req.col);
            v_waddr = VW'(req.row);
            wdata   = req.value;
            if (accept) begin
               case (req.command)
                  lu_pkg::CMD_LOAD_M:
                     m_we = (32'(req.row) < MAX_DIM) && (32'(req.col) < MAX_DIM);
                  lu_pkg::CMD_LOAD_V:
                     v_we = (32'(req.row) < MAX_DIM);
                  lu_pkg::CMD_SOLVE: begin
                     if (size_ff == '0) begin
                        n_in = DW'(1);
                     end else if (32'(size_ff) > DIM_CAP) begin
                        n_in = DW'(DIM_CAP);
                     end else begin
                        n_in = size_ff;
                     end
                     ovf_in   = 1'b0;
                     phase_in = PH_U;
                     p_in     = '0;
                     j_in     = '0;
                     r_in     = '0;
                     state_in = S_DISP;
                  end
                  default: ;
               endcase
            end
         end
         S_DISP: begin
            case (phase_ff)
               PH_U: begin
                  if (r_ff < p_ff && j_ff < n_ff) begin
                     div_in   = 1'b0;
                     state_in = S_RD_T;
                  end else begin
                     state_in = S_PIV_RD;
                  end
               end
               PH_L: begin
                  if (i_ff < n_ff) begin
                     div_in   = !(r_ff < p_ff);
                     state_in = S_RD_T;
                  end else if (p_ff + DW'(1) == n_ff) begin
                     phase_in = PH_F;
                     i_in     = '0;
                     j_in     = '0;
                  end else begin
                     phase_in = PH_U;
                     p_in     = p_ff + DW'(1);
                     j_in     = p_ff + DW'(1);
                     r_in     = '0;
                  end
               end
               PH_F: begin
                  if (i_ff < n_ff) begin
                     if (j_ff < i_ff) begin
                        div_in   = 1'b0;
                        state_in = S_RD_T;
                     end else begin
                        i_in = i_ff + DW'(1);
                        j_in = '0;
                     end
                  end else begin
                     phase_in = PH_B;
                     i_in     = n_ff;
                     j_in     = n_ff;
                  end
               end
               PH_B: begin
                  if (i_ff != '0) begin
                     div_in   = !(j_ff < n_ff);
                     state_in = S_RD_T;
                  end else begin
                     phase_in = PH_O;
                  end
               end
               default: begin
                  state_in = (i_ff < n_ff) ? S_OUT_RD : S_IDLE;
               end
            endcase
         end
         S_RD_T: state_in = S_RD_A;
         S_RD_A: begin
            t_in     = rd_data;
            state_in = S_RD_B;
         end
         S_RD_B: begin
            a_in = rd_data;
            if (div_ff) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               state_in = S_CAP_B;
            end
         end
         S_CAP_B: begin
            b_in     = rd_data;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = a_ff * b_ff;
            state_in = S_UPD;
         end
         S_UPD, S_DIV: begin
            if (state_ff == S_UPD || div_done) begin
               if (state_ff == S_DIV) begin
                  wdata  = div_res.value;
                  ovf_in = ovf_ff | div_res.ovf;
               end else begin
                  ovf_in = ovf_ff | upd_ovf;
               end
               m_we     = !t_desc.vec;
               v_we     = t_desc.vec;
               state_in = S_DISP;
               case (phase_ff)
                  PH_U: begin
                     r_in = r_ff + DW'(1);
                     if (r_ff + DW'(1) == p_ff) begin
                        r_in = '0;
                        j_in = j_ff + DW'(1);
                     end
                  end
                  PH_L: begin
                     if (div_ff) begin
                        i_in = i_ff + DW'(1);
                        r_in = '0;
                     end else begin
                        r_in = r_ff + DW'(1);
                     end
                  end
                  PH_B: begin
                     if (div_ff) begin
                        i_in = im1;
                        j_in = im1;
                     end else begin
                        j_in = j_ff + DW'(1);
                     end
                  end
                  default: j_in = j_ff + DW'(1);
               endcase
            end
         end
         S_PIV_RD: state_in = S_PIV_CHK;
         S_PIV_CHK: begin
            if (rd_data == '0 || piv_mag < {1'b0, pmin_ff}) begin
               rv_in    = 1'b1;
               ridx_in  = '0;
               rsol_in  = '0;
               rlast_in = 1'b1;
               rstat_in = lu_pkg::ST_PIVOT;
               phase_in = PH_O;
               i_in     = n_ff - DW'(1);
               state_in = S_OUT_HOLD;
            end else begin
               phase_in = PH_L;
               i_in     = p_ff + DW'(1);
               r_in     = '0;
               state_in = S_DISP;
            end
         end
         S_OUT_RD: state_in = S_OUT_CAP;
         S_OUT_CAP: begin
            rv_in    = 1'b1;
            ridx_in  = i_ff[IW-1:0];
            rsol_in  = rd_data;
            rlast_in = (i_ff == n_ff - DW'(1));
            rstat_in = ovf_ff ? lu_pkg::ST_OVF : lu_pkg::ST_OK;
            state_in = S_OUT_HOLD;
         end
         S_OUT_HOLD: begin
            if (rsp.ready) begin
               rv_in    = 1'b0;
               i_in     = i_ff + DW'(1);
               state_in = S_DISP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_O;
         size_ff  <= DW'(16);
         pmin_ff  <= (W-1)'(1);
         ovf_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         size_ff  <= size_in;
         pmin_ff  <= pmin_in;
         ovf_ff   <= ovf_in;
         rv_ff    <= rv_in;
      end
      n_ff      <= n_in;
      p_ff      <= p_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      r_ff      <= r_in;
      div_ff    <= div_in;
      t_ff      <= t_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      prod_ff   <= prod_in;
      rd_vec_ff <= rd_desc.vec;
      ridx_ff   <= ridx_in;
      rsol_ff   <= rsol_in;
      rlast_ff  <= rlast_in;
      rstat_ff  <= rstat_in;
   end

   lu_ram #(.WIDTH(W), .DEPTH(M_DEPTH)) u_mat (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (m_waddr),
      .wr_data (wdata),
      .rd_addr (m_addr(rd_desc.row, rd_desc.col)),
      .rd_data (m_rdata)
   );

   lu_ram #(.WIDTH(W), .DEPTH(MAX_DIM)) u_vec (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (wdata),
      .rd_addr (VW'(rd_desc.row)),
      .rd_data (v_rdata)
   );

   lu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (t_ff),
      .divisor  (rd_data),
      .done     (div_done),
      .res      (div_res)
   );

   assign req.ready    = (state_ff == S_IDLE);
   assign csr.ready    = 1'b1;
   assign rsp.valid    = rv_ff;
   assign rsp.index    = ridx_ff;
   assign rsp.solution = rsol_ff;
   assign rsp.last     = rlast_ff;
   assign rsp.status   = rstat_ff;

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken while a response is pending");

   a_pivot_error_form: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == lu_pkg::ST_PIVOT) |-> (rsp.last && rsp.solution == '0))
      else $error("pivot error response malformed");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside divide state");

   a_solve_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req.command == lu_pkg::CMD_SOLVE) |=> (state_ff == S_DISP && !ovf_ff))
      else $error("solve did not start cleanly");

   a_no_store_write_on_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT_HOLD) |-> (!m_we && !v_we))
      else $error("store written while a response is held");
endmodule

@@ tb/lu_solver_checker.sv @@
// ----------------------------------------------------------------------------
// LU solver checker
// Watches the request, response and register channels. A local Doolittle
// model in Q16.16 predicts each solve, and every response is compared with
// the oldest prediction.
// ----------------------------------------------------------------------------
module lu_solver_checker (
   input  logic clock,
   input  logic reset,
   lu_req_if    req,
   lu_rsp_if    rsp,
   lu_csr_if    csr,
   output int   errors,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [lu_pkg::IDX_W-1:0] index;
      int                       solution;
      logic                     last;
      lu_pkg::status_type       status;
   } solution_type;

   int           mat [lu_pkg::HARD_CAP*lu_pkg::HARD_CAP];
   int           vec [lu_pkg::HARD_CAP];
   logic [4:0]   size_reg;
   logic [30:0]  pivot_reg;
   bit           sat_seen;
   solution_type solution_q[$];

   assign pending = solution_q.size();

   function automatic int sat32(longint v);
      if (v > longint'(32'sh7fffffff)) begin
         sat_seen = 1;
         return 32'sh7fffffff;
      end
      if (v < -longint'(64'sh80000000)) begin
         sat_seen = 1;
         return 32'sh80000000;
      end
      return int'(v);
   endfunction

   // rounded product, floor shift
   function automatic longint q_mul(int a, int b);
      longint pr;
      pr = longint'(a) * longint'(b) + 64'sd32768;
      return pr >>> 16;
   endfunction

   function automatic int q_submul(int v, int a, int b);
      return sat32(longint'(v) - q_mul(a, b));
   endfunction

   function automatic int q_div(int a, int b);
      return sat32((longint'(a) * 64'sd65536) / longint'(b));
   endfunction

   function automatic bit pivot_too_small(int p);
      logic [31:0] mag;
      mag = p < 0 ? -p : p;
      return p == 0 || mag < {1'b0, pivot_reg};
   endfunction

   task automatic predict_solution();
      int n;
      int piv;
      solution_type s;
      n = size_reg;
      if (n < 1) n = 1;
      if (n > lu_pkg::HARD_CAP) n = lu_pkg::HARD_CAP;
      sat_seen = 0;
      for (int p = 0; p < n; p++) begin
         for (int j = p; j < n; j++)
            for (int r = 0; r < p; r++)
               mat[p*16+j] = q_submul(mat[p*16+j], mat[p*16+r], mat[r*16+j]);
         piv = mat[p*16+p];
         if (pivot_too_small(piv)) begin
            s.index = '0;
            s.solution = 0;
            s.last = 1;
            s.status = lu_pkg::ST_PIVOT;
            solution_q.push_back(s);
            return;
         end
         for (int i = p + 1; i < n; i++) begin
            for (int r = 0; r < p; r++)
               mat[i*16+p] = q_submul(mat[i*16+p], mat[i*16+r], mat[r*16+p]);
            mat[i*16+p] = q_div(mat[i*16+p], piv);
         end
      end
      for (int i = 0; i < n; i++)
         for (int j = 0; j < i; j++)
            vec[i] = q_submul(vec[i], mat[i*16+j], vec[j]);
      for (int i = n - 1; i >= 0; i--) begin
         for (int j = i + 1; j < n; j++)
            vec[i] = q_submul(vec[i], mat[i*16+j], vec[j]);
         vec[i] = q_div(vec[i], mat[i*16+i]);
      end
      for (int i = 0; i < n; i++) begin
         s.index = lu_pkg::IDX_W'(i);
         s.solution = vec[i];
         s.last = (i == n - 1);
         s.status = sat_seen ? lu_pkg::ST_OVF : lu_pkg::ST_OK;
         solution_q.push_back(s);
      end
   endtask

   always @(posedge clock) begin
      solution_type s;
      int           err_now;
      err_now = 0;
      if (reset) begin
         errors <= 0;
         size_reg = 5'd16;
         pivot_reg = 31'd1;
         solution_q.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (lu_pkg::csr_reg_type'(csr.index))
               lu_pkg::REG_MATRIX_SIZE: size_reg = csr.data[4:0];
               lu_pkg::REG_PIVOT_MIN:   pivot_reg = csr.data[30:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (solution_q.size() == 0) begin
               $error("response with no solution pending: index %0d", rsp.index);
               err_now++;
            end else begin
               s = solution_q.pop_front();
               if (rsp.index !== s.index) begin
                  $error("index mismatch: expected %0d, got %0d", s.index, rsp.index);
                  err_now++;
               end
               if (rsp.solution !== s.solution) begin
                  $error("solution mismatch: expected %0d, got %0d", s.solution,
                         rsp.solution);
                  err_now++;
               end
               if (rsp.last !== s.last) begin
                  $error("last mismatch: expected %0d, got %0d", s.last, rsp.last);
                  err_now++;
               end
               if (rsp.status !== s.status) begin
                  $error("status mismatch: expected %0d, got %0d", s.status, rsp.status);
                  err_now++;
               end
            end
         end
         // solve is predicted after the response check so a same-edge
         // response can never pop an expectation of the new solve
         if (req.valid && req.ready) begin
            case (lu_pkg::command_type'(req.command))
               lu_pkg::CMD_LOAD_M: mat[{req.row, req.col}] = req.value;
               lu_pkg::CMD_LOAD_V: vec[req.row] = req.value;
               lu_pkg::CMD_SOLVE:  predict_solution();
               default: ;
            endcase
         end
         errors <= errors + err_now;
      end
   end
endmodule

@@ tb/tb_lu_decomposition_solver.sv @@
// ----------------------------------------------------------------------------
// LU solver testbench
// Loads systems of several sizes (well conditioned, random, zero leading pivot) with
// random gaps on both channels, solves them and lets the checker compare.
// ----------------------------------------------------------------------------
module tb_lu_decomposition_solver;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 200000;

   logic clock = 0;
   logic reset = 1;
   int   errors;
   int   pending;
   int   idle_cycles = 0;
   int   req_count = 0;
   bit   m_written [256];
   bit   v_written [16];

   lu_req_if req_ch();
   lu_rsp_if rsp_ch();
   lu_csr_if csr_ch();

   lu_decomposition_solver dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch)
   );

   lu_solver_checker checker_i (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch),
      .errors(errors), .pending(pending)
   );

   always #6 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.command = lu_pkg::CMD_LOAD_M;
      req_ch.row = 0;
      req_ch.col = 0;
      req_ch.value = 0;
      rsp_ch.ready = 0;
      csr_ch.valid = 0;
      csr_ch.index = lu_pkg::REG_MATRIX_SIZE;
      csr_ch.data = 0;
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // response side: random stalls, sometimes none
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ch.ready = 0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   task automatic send_request(lu_pkg::command_type cmd, int row, int col, int value);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_ch.command = cmd;
      req_ch.row = row;
      req_ch.col = col;
      req_ch.value = value;
      req_ch.valid = 1;
      do @(posedge clock); while (!req_ch.ready);
      if (cmd == lu_pkg::CMD_LOAD_M) m_written[row*16+col] = 1;
      if (cmd == lu_pkg::CMD_LOAD_V) v_written[row] = 1;
      req_count++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 0;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(lu_pkg::csr_reg_type idx, logic [31:0] data);
      @(negedge clock);
      csr_ch.index = idx;
      csr_ch.data = data;
      csr_ch.valid = 1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 0;
   endtask

   function automatic int diag_value(int n);
      int mag;
      mag = $urandom_range(2 * n, 4 * n) << 16;
      return $urandom_range(0, 1) ? mag : -mag;
   endfunction

   function automatic int off_value();
      return $urandom_range(0, 131072) - 65536;
   endfunction

   function automatic int rhs_value();
      return $urandom_range(0, 1 << 22) - (1 << 21);
   endfunction

   // kind 0 well conditioned, 1 random words, 2 zero leading pivot
   task automatic load_system(int n, int kind);
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c < n; c++)
            send_request(lu_pkg::CMD_LOAD_M, r, c,
                         kind == 1 ? int'($urandom) :
                         (r == c ? ((kind == 2 && r == 0) ? 0 : diag_value(n))
                                 : off_value()));
         send_request(lu_pkg::CMD_LOAD_V, r, 0, kind == 1 ? int'($urandom) : rhs_value());
      end
   endtask

   // never solve over entries that were not written since reset
   task automatic fill_missing(int n);
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c < n; c++)
            if (!m_written[r*16+c])
               send_request(lu_pkg::CMD_LOAD_M, r, c,
                            r == c ? diag_value(n) : off_value());
         if (!v_written[r]) send_request(lu_pkg::CMD_LOAD_V, r, 0, rhs_value());
      end
   endtask

   task automatic run_phase(logic [31:0] size_data, logic [31:0] pivot_data, int count);
      int n;
      int pick;
      int stop_at;
      wait_idle();
      write_reg(lu_pkg::REG_MATRIX_SIZE, size_data);
      write_reg(lu_pkg::REG_PIVOT_MIN, pivot_data);
      n = size_data[4:0];
      if (n < 1) n = 1;
      if (n > 16) n = 16;
      stop_at = req_count + count;
      while (req_count < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            load_system(n, 0);
         end else if (pick < 62) begin
            repeat ($urandom_range(1, 4))
               send_request(lu_pkg::CMD_LOAD_M, $urandom_range(0, n - 1),
                            $urandom_range(0, n - 1), off_value());
            fill_missing(n);
         end else if (pick < 72) begin
            load_system(n, 1);
         end else if (pick < 80) begin
            load_system(n, 2);
         end else if (pick < 88) begin
            fill_missing(n);
         end else begin
            // stray writes anywhere, unknown commands
            repeat ($urandom_range(1, 5))
               send_request($urandom_range(0, 1) ? lu_pkg::CMD_LOAD_M
                                                 : lu_pkg::command_type'(2'd3),
                            $urandom_range(0, 15), $urandom_range(0, 15), int'($urandom));
            continue;
         end
         fill_missing(n);
         send_request(lu_pkg::CMD_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15),
                      int'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: one-by-one systems at the edges
      write_reg(lu_pkg::REG_MATRIX_SIZE, 32'd1);
      write_reg(lu_pkg::REG_PIVOT_MIN, 32'd0);
      send_request(lu_pkg::CMD_LOAD_M, 0, 0, 1);
      send_request(lu_pkg::CMD_LOAD_V, 0, 0, 32'h7fffffff);
      send_request(lu_pkg::CMD_SOLVE, 0, 0, 0);          // quotient saturates
      send_request(lu_pkg::CMD_LOAD_M, 0, 0, 0);
      send_request(lu_pkg::CMD_SOLVE, 15, 15, -1);       // zero pivot, no threshold
      send_request(lu_pkg::CMD_LOAD_M, 0, 0, 32'h80000000);
      send_request(lu_pkg::CMD_LOAD_V, 0, 0, 32'h80000000);
      send_request(lu_pkg::CMD_SOLVE, 0, 0, 0);
      send_request(lu_pkg::command_type'(2'd3), 15, 15, 32'hffffffff);
      send_request(lu_pkg::CMD_LOAD_M, 15, 15, 32'h7fffffff);
      send_request(lu_pkg::CMD_LOAD_V, 15, 0, 32'h80000000);
      send_request(lu_pkg::CMD_SOLVE, 0, 0, 0);          // repeated solve on stores
      wait_idle();
      write_reg(lu_pkg::REG_MATRIX_SIZE, 32'd2);
      write_reg(lu_pkg::REG_PIVOT_MIN, 32'd65536);
      send_request(lu_pkg::CMD_LOAD_M, 0, 0, 32'h8000);  // below threshold
      send_request(lu_pkg::CMD_LOAD_M, 0, 1, 32'h10000);
      send_request(lu_pkg::CMD_LOAD_M, 1, 0, 32'h10000);
      send_request(lu_pkg::CMD_LOAD_M, 1, 1, 32'h30000);
      send_request(lu_pkg::CMD_LOAD_V, 0, 0, 32'h20000);
      send_request(lu_pkg::CMD_LOAD_V, 1, 0, -32'sh10000);
      send_request(lu_pkg::CMD_SOLVE, 0, 0, 0);
      send_request(lu_pkg::CMD_LOAD_M, 0, 0, 32'h20000);
      send_request(lu_pkg::CMD_SOLVE, 0, 0, 0);

      run_phase(32'd1, 32'd0, 8);
      run_phase(32'd2, 32'd1, 10);
      run_phase(32'd3, 32'd65536, 12);
      run_phase(32'd4, 32'd1, 15);
      run_phase(32'd0, 32'hffffffff, 4);                 // size acts as one
      run_phase(32'd5, 32'h7fffffff, 8);                 // every pivot fails

      // full-size system; size clamps to 16
      wait_idle();
      write_reg(lu_pkg::REG_MATRIX_SIZE, 32'd31);
      write_reg(lu_pkg::REG_PIVOT_MIN, 32'd1);
      fill_missing(16);
      send_request(lu_pkg::CMD_SOLVE, 0, 0, 0);

      wait_idle();
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
